// ----- rtl/core/sepf_pkg.sv -----
package sepf_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxBytes   = 4;
  localparam int unsigned SlotW      = $clog2(MaxBytes);

  localparam logic [ByteW-1:0] SyncReset   = 8'd224;
  localparam logic [ByteW-1:0] EscapeReset = 8'd208;

  localparam logic [CfgIdxW-1:0] RegSync   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEscape = 2'd1;

  localparam logic FuncHeader  = 1'b0;
  localparam logic FuncPayload = 1'b1;

  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [SlotW-1:0]               last_slot;
    logic                           eof;
  } entry_t;

endpackage

// ----- rtl/core/sepf_front.sv -----
module sepf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sepf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sepf_pkg::ByteW-1:0]    cfg_wdata_i,
  input  logic                          accept_i,
  input  logic                          func_i,
  input  logic [sepf_pkg::ByteW-1:0]    destination_i,
  input  logic [sepf_pkg::ByteW-1:0]    payload_length_i,
  input  logic [sepf_pkg::ByteW-1:0]    data_byte_i,
  output logic                          push_o,
  output sepf_pkg::entry_t              entry_o
);
  import sepf_pkg::*;

  logic [ByteW-1:0] sync_q, escape_q;
  logic             open_q, open_d;
  logic [ByteW-1:0] remain_q, remain_d;
  logic [ByteW-1:0] sum_q, sum_d;

  logic [ByteW-1:0] count, hdr_sum, new_sum, remain_dec;
  logic             is_hdr, match, close;

  assign is_hdr     = (func_i == FuncHeader);
  assign count      = payload_length_i + 8'd1;
  assign hdr_sum    = destination_i + count;
  assign new_sum    = sum_q + data_byte_i;
  assign remain_dec = remain_q - 8'd1;
  assign close      = (remain_dec == '0);
  assign match      = (data_byte_i == sync_q) || (data_byte_i == escape_q);

  assign push_o = accept_i && (is_hdr || open_q);

  always_comb begin
    entry_o  = '0;
    open_d   = open_q;
    remain_d = remain_q;
    sum_d    = sum_q;
    if (is_hdr) begin
      entry_o.bytes[0]  = sync_q;
      entry_o.bytes[1]  = destination_i;
      entry_o.bytes[2]  = count;
      entry_o.bytes[3]  = hdr_sum;
      entry_o.eof       = (payload_length_i == '0);
      entry_o.last_slot = entry_o.eof ? 2'd3 : 2'd2;
      open_d            = (payload_length_i != '0);
      remain_d          = payload_length_i;
      sum_d             = hdr_sum;
    end else begin
      entry_o.eof = close;
      if (match) begin
        entry_o.bytes[0]  = escape_q;
        entry_o.bytes[1]  = data_byte_i - 8'd1;
        entry_o.bytes[2]  = new_sum;
        entry_o.last_slot = close ? 2'd2 : 2'd1;
      end else begin
        entry_o.bytes[0]  = data_byte_i;
        entry_o.bytes[1]  = new_sum;
        entry_o.last_slot = close ? 2'd1 : 2'd0;
      end
      if (open_q) begin
        open_d   = !close;
        remain_d = remain_dec;
        sum_d    = new_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q   <= SyncReset;
      escape_q <= EscapeReset;
      open_q   <= 1'b0;
      remain_q <= '0;
      sum_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == RegSync) begin
        sync_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == RegEscape) begin
        escape_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        open_q   <= open_d;
        remain_q <= remain_d;
        sum_q    <= sum_d;
      end
    end
  end

endmodule

// ----- rtl/core/sepf_fifo.sv -----
module sepf_fifo #(
  parameter int unsigned Depth = sepf_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sepf_pkg::entry_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output sepf_pkg::entry_t rdata_o
);
  import sepf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/sepf_back.sv -----
module sepf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  sepf_pkg::entry_t           entry_i,
  output logic                       take_o,
  output logic                       empty,
  input  logic                       pop,
  output logic [sepf_pkg::ByteW-1:0] out_byte_o,
  output logic                       end_of_frame_o
);
  import sepf_pkg::*;

  entry_t           ent_q;
  logic             ent_vld_q;
  logic [SlotW-1:0] slot_q;
  logic [ByteW-1:0] byte_q;
  logic             eof_q, out_vld_q;
  logic             adv, at_last;

  assign adv     = !out_vld_q || pop;
  assign at_last = (slot_q == ent_q.last_slot);
  assign take_o  = valid_i && (!ent_vld_q || (adv && at_last));

  assign empty          = !out_vld_q;
  assign out_byte_o     = byte_q;
  assign end_of_frame_o = eof_q;

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      ent_q <= entry_i;
    end
    if (adv && ent_vld_q) begin
      byte_q <= ent_q.bytes[slot_q];
      eof_q  <= ent_q.eof && at_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
      slot_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        out_vld_q <= ent_vld_q;
      end
      if (take_o) begin
        ent_vld_q <= 1'b1;
        slot_q    <= '0;
      end else if (adv && ent_vld_q) begin
        if (at_last) begin
          ent_vld_q <= 1'b0;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/sync_escape_packet_framer.sv -----
// Path: an accepted word is written to the queue, then loaded into the back stage's entry register.
// Throughput: one result word per cycle while pop is held; a header takes 3 or 4 slots,
// a payload word 1 to 3 (2 or 3 when escaped); bytes leave through the output byte register.
// The byte serializer in the back stage sets the rate.
// Reset: packet closed, sum and count cleared, queues empty, sync 224, escape 208.
module sync_escape_packet_framer #(
  parameter int unsigned QueueDepth = sepf_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sepf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sepf_pkg::ByteW-1:0]    cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          func_i,
  input  logic [sepf_pkg::ByteW-1:0]    destination_i,
  input  logic [sepf_pkg::ByteW-1:0]    payload_length_i,
  input  logic [sepf_pkg::ByteW-1:0]    data_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [sepf_pkg::ByteW-1:0]    out_byte_o,
  output logic                          end_of_frame_o
);
  import sepf_pkg::*;

  logic   accept, front_push, q_valid, q_take;
  entry_t front_entry, q_entry;

  assign accept = push && !full;

  sepf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .accept_i         (accept),
    .func_i           (func_i),
    .destination_i    (destination_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .push_o           (front_push),
    .entry_o          (front_entry)
  );

  sepf_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_entry),
    .full_o  (full),
    .pop_i   (q_take),
    .valid_o (q_valid),
    .rdata_o (q_entry)
  );

  sepf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .entry_i        (q_entry),
    .take_o         (q_take),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

// ----- verif/sync_escape_packet_framer_tb.sv -----
`timescale 1ns / 100ps

module sync_escape_packet_framer_tb;
  import sepf_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;
  localparam int unsigned        QuietLimit = 2000;
  localparam int unsigned        NumRows    = 28;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             eof;
  } line_byte_t;

  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] reg_idx;
    logic               fn;
    logic [ByteW-1:0]   dst;
    logic [ByteW-1:0]   len;
    logic [ByteW-1:0]   dat;
    logic               typed;
    logic [2:0]         n_exp;
    logic [31:0]        typed_word;
    logic               eof_last;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [ByteW-1:0]   cfg_wdata = '0;
  logic               push = 1'b0;
  logic               full;
  logic               func_i = FuncHeader;
  logic [ByteW-1:0]   destination_i = '0;
  logic [ByteW-1:0]   payload_length_i = '0;
  logic [ByteW-1:0]   data_byte_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [ByteW-1:0]   out_byte_o;
  logic               end_of_frame_o;

  logic [ByteW-1:0] sync_r = SyncReset;
  logic [ByteW-1:0] esc_r = EscapeReset;
  logic             open_r = 1'b0;
  logic [ByteW-1:0] remaining_r = '0;
  logic [ByteW-1:0] sum_r = '0;

  line_byte_t  frame_out[$];
  line_byte_t  line_q[$];
  int unsigned mismatches = 0;
  int unsigned rx_words = 0;
  int unsigned rx_cyc = 0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;
  logic        calm_tx = 1'b0;
  line_byte_t  want;

  stim_row_t dir_rows [NumRows] = '{
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'hAB, 1'b1, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncHeader,  8'h00, 8'h00, 8'h00, 1'b1, 3'd4, 32'hE0000101, 1'b1},
    '{1'b0, RegSync, FuncHeader,  8'hFF, 8'h00, 8'h00, 1'b1, 3'd4, 32'hE0FF0100, 1'b1},
    '{1'b0, RegSync, FuncHeader,  8'h12, 8'h01, 8'h00, 1'b1, 3'd3, 32'hE0120200, 1'b0},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'hE0, 1'b1, 3'd3, 32'hD0DFF400, 1'b1},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'h55, 1'b1, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncHeader,  8'h00, 8'h02, 8'h00, 1'b1, 3'd3, 32'hE0000300, 1'b0},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'hD0, 1'b1, 3'd2, 32'hD0CF0000, 1'b0},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'hFF, 1'b1, 3'd2, 32'hFFD20000, 1'b1},
    '{1'b0, RegSync, FuncHeader,  8'h01, 8'hFE, 8'h00, 1'b1, 3'd3, 32'hE001FF00, 1'b0},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'h01, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncHeader,  8'h80, 8'h03, 8'h00, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'hE1, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'hCF, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'h7F, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncHeader,  8'h07, 8'hFF, 8'h00, 1'b1, 3'd3, 32'hE0070000, 1'b0},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'hFF, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncHeader,  8'hAA, 8'h01, 8'h00, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'hD1, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'h80, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b1, RegSync, FuncHeader,  8'h00, 8'h00, 8'h7E, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b1, RegEscape, FuncHeader, 8'h00, 8'h00, 8'h7E, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncHeader,  8'h00, 8'h01, 8'h00, 1'b1, 3'd3, 32'h7E000200, 1'b0},
    '{1'b0, RegSync, FuncPayload, 8'h00, 8'h00, 8'h7E, 1'b1, 3'd3, 32'h7E7D8000, 1'b1},
    '{1'b1, RegSpareLo, FuncHeader, 8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 32'h00000000, 1'b0},
    '{1'b0, RegSync, FuncHeader,  8'h3C, 8'h00, 8'h00, 1'b0, 3'd0, 32'h00000000, 1'b0}
  };

  sync_escape_packet_framer dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .push             (push),
    .full             (full),
    .func_i           (func_i),
    .destination_i    (destination_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .empty            (empty),
    .pop              (pop),
    .out_byte_o       (out_byte_o),
    .end_of_frame_o   (end_of_frame_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void frame_word(input logic fn, input logic [ByteW-1:0] dst,
                                     input logic [ByteW-1:0] len,
                                     input logic [ByteW-1:0] dat);
    line_byte_t lb;
    logic [ByteW-1:0] cnt;
    frame_out = {};
    lb.eof = 1'b0;
    if (fn == FuncHeader) begin
      cnt = len + 8'd1;
      lb.value = sync_r;
      frame_out.push_back(lb);
      lb.value = dst;
      frame_out.push_back(lb);
      lb.value = cnt;
      frame_out.push_back(lb);
      sum_r = dst + cnt;
      remaining_r = len;
      open_r = 1'b1;
      if (len == 8'd0) begin
        lb.value = sum_r;
        lb.eof = 1'b1;
        frame_out.push_back(lb);
        open_r = 1'b0;
      end
    end else if (open_r) begin
      if (dat == sync_r || dat == esc_r) begin
        lb.value = esc_r;
        frame_out.push_back(lb);
        lb.value = dat - 8'd1;
        frame_out.push_back(lb);
      end else begin
        lb.value = dat;
        frame_out.push_back(lb);
      end
      sum_r = sum_r + dat;
      remaining_r = remaining_r - 8'd1;
      if (remaining_r == 8'd0) begin
        lb.value = sum_r;
        lb.eof = 1'b1;
        frame_out.push_back(lb);
        open_r = 1'b0;
      end
    end
  endfunction

  function automatic logic [ByteW-1:0] payload_pick();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0, 1: return sync_r;
      2, 3: return esc_r;
      4: return sync_r + 8'd1;
      5: return esc_r - 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(input string what, input line_byte_t exp_b,
                               input line_byte_t got_b);
    if (mismatches < 10)
      $display("%0t %s: want %h eof %b, got %h eof %b", $time, what,
               exp_b.value, exp_b.eof, got_b.value, got_b.eof);
    mismatches++;
  endtask

  task automatic send_word(input logic fn, input logic [ByteW-1:0] dst,
                           input logic [ByteW-1:0] len, input logic [ByteW-1:0] dat,
                           input logic typed, input logic [2:0] n_exp,
                           input logic [31:0] typed_word, input logic eof_last);
    line_byte_t lb;
    int i;
    while (!calm_tx && $urandom_range(99) < 10) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push             <= 1'b1;
    func_i           <= fn;
    destination_i    <= dst;
    payload_length_i <= len;
    data_byte_i      <= dat;
    do @(posedge clk); while (full);
    frame_word(fn, dst, len, dat);
    if (typed) begin
      for (i = 0; i < int'(n_exp); i++) begin
        lb.value = typed_word[31-8*i -: 8];
        lb.eof   = eof_last && (i == int'(n_exp) - 1);
        line_q.push_back(lb);
      end
    end else begin
      foreach (frame_out[i]) line_q.push_back(frame_out[i]);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    push <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegSync) sync_r = val;
    else if (idx == RegEscape) esc_r = val;
  endtask

  task automatic send_payload();
    send_word(FuncPayload, 8'($urandom), 8'($urandom), payload_pick(), 1'b0, 3'd0, 32'h0,
              1'b0);
  endtask

  task automatic run_packets(input int quota);
    int sent;
    int p;
    int n_pl;
    int k;
    int q;
    logic [ByteW-1:0] len;
    sent = 0;
    while (sent < quota) begin
      p = $urandom_range(99);
      if (p < 8) begin
        if (open_r) sent++;
        send_payload();
      end else begin
        q = $urandom_range(99);
        if (q < 70) len = 8'($urandom_range(6));
        else if (q < 90) len = 8'($urandom_range(20, 7));
        else len = 8'($urandom);
        send_word(FuncHeader, 8'($urandom), len, 8'($urandom), 1'b0, 3'd0, 32'h0, 1'b0);
        sent++;
        if (p < 86 && len <= 8'd24) n_pl = int'(len);
        else n_pl = $urandom_range((len < 8'd4) ? int'(len) : 4);
        for (k = 0; k < n_pl; k++) begin
          send_payload();
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      rx_cyc++;
      if (pop && !empty) begin
        if (line_q.size() == 0) begin
          note_mismatch("unexpected word", '0, {out_byte_o, end_of_frame_o});
        end else begin
          want = line_q.pop_front();
          if (out_byte_o !== want.value || end_of_frame_o !== want.eof)
            note_mismatch("word differs", want, {out_byte_o, end_of_frame_o});
        end
        rx_words++;
        if (rx_words == 150 || rx_words == 600) hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_cyc >= 400 && rx_cyc < 700) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("sync_escape_packet_framer: mismatch");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    int r;
    int k;
    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    for (r = 0; r < NumRows; r++) begin
      if (dir_rows[r].is_cfg)
        write_reg(dir_rows[r].reg_idx, dir_rows[r].dat);
      else
        send_word(dir_rows[r].fn, dir_rows[r].dst, dir_rows[r].len, dir_rows[r].dat,
                  dir_rows[r].typed, dir_rows[r].n_exp, dir_rows[r].typed_word,
                  dir_rows[r].eof_last);
    end

    write_reg(RegSpareHi, 8'hA5);
    write_reg(RegSync, 8'h00);
    write_reg(RegEscape, 8'hFF);
    run_packets(15);

    write_reg(RegSync, 8'h7E);
    write_reg(RegEscape, 8'h7E);
    calm_tx = 1'b1;
    run_packets(30);
    calm_tx = 1'b0;

    write_reg(RegSync, 8'hFF);
    write_reg(RegEscape, 8'h00);
    run_packets(15);

    write_reg(RegSync, 8'($urandom));
    write_reg(RegEscape, 8'($urandom));
    run_packets(15);

    // hold a full-length packet open: count byte wraps to zero
    send_word(FuncHeader, 8'($urandom), 8'hFF, 8'($urandom), 1'b0, 3'd0, 32'h0, 1'b0);
    for (k = 0; k < 255; k++) send_payload();

    push <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && line_q.size() == 0)
      $display("sync_escape_packet_framer: match");
    else
      $display("sync_escape_packet_framer: mismatch");
    $finish;
  end

endmodule
